// File: rtl/core/plfe_pkg.sv
`default_nettype none

package plfe_pkg;

	// width of the millisecond time base that the fader keeps
	localparam int TIME_BITS = 16;
	localparam int DUR_W     = 16;
	localparam int CMP_W     = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;

	localparam int LVL_W     = 8;
	localparam int ACC_W     = 17;
	localparam int PCT_W     = 7;

	// shared divider: numerator, divisor and quotient widths
	localparam int NUM_W     = 34;
	localparam int DEN_W     = 17;
	localparam int QUO_W     = 17;
	localparam int CNT_W     = $clog2(NUM_W + 1);
	localparam int FRAC_SH   = 17;

	localparam logic [ACC_W-1:0] FULL_Q16  = ACC_W'(65536);
	localparam int               PCT_SCALE = 200;
	localparam int               PCT_SH    = 17;
	localparam int               PCT_PROD_W = 25;
	localparam logic [PCT_W-1:0] PCT_MAX   = PCT_W'(100);
	localparam logic [LVL_W-1:0] LVL_MAX   = LVL_W'(255);

	localparam logic [7:0] MIN_IV_RST = 8'd20;

	typedef enum logic [2:0] {
		FN_TICK   = 3'd0,
		FN_START  = 3'd1,
		FN_SET    = 3'd2,
		FN_STOP   = 3'd3,
		FN_SLOWER = 3'd4,
		FN_FASTER = 3'd5
	} func_t;

	typedef enum logic {
		CFG_ENABLED    = 1'b0,
		CFG_STEP_FLOOR = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		DOP_IV,
		DOP_FRAC,
		DOP_MAG
	} div_op_t;

endpackage

`default_nettype wire

// File: rtl/core/pwm_led_fade_engine.sv
`default_nettype none

// channel   direction  handshake              word
// item      in         item_valid/item_stall  func, level, amount, now_ms
// result    out        result_valid/result_stall  out_level, fading, progress, target_level
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// one word at a time, from acceptance to the next acceptance: set, stop, no-op,
// disabled words and ticks that only check the time or snap to the target go from
// decode straight to the result, a start, slow-down or speed-up that settles at once
// may also pass through S_START, one that runs the divider adds one division, and a
// tick that moves the level runs two, all on the 34-step restoring divider shared by every division.
// arst_n clears all state; enabled comes up 1 and the step floor 20.
// a new word is taken while a finished result still waits on result_stall; the
// next result then holds in its last cycle until that one leaves.
module pwm_led_fade_engine (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        item_valid,
	output logic                             item_stall,
	input  wire logic [2:0]                  func,
	input  wire logic [plfe_pkg::LVL_W-1:0]  level,
	input  wire logic [15:0]                 amount,
	input  wire logic [31:0]                 now_ms,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output logic [plfe_pkg::LVL_W-1:0]       out_level,
	output logic                             fading,
	output logic [plfe_pkg::PCT_W-1:0]       progress,
	output logic [plfe_pkg::LVL_W-1:0]       target_level,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic                        cfg_index,
	input  wire logic [7:0]                  cfg_data
);
	import plfe_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_START,
		S_DIV,
		S_POST,
		S_FIN
	} state_t;

	state_t                  state_q;
	div_op_t                 dop_q;

	logic                    enabled_q;
	logic [7:0]              min_iv_q;

	logic [LVL_W-1:0]        cur_q;
	logic [LVL_W-1:0]        goal_q;
	logic [TIME_BITS-1:0]    last_q;
	logic [DUR_W-1:0]        step_iv_q;
	logic [DUR_W-1:0]        rem_q;
	logic [ACC_W-1:0]        acc_q;

	func_t                   func_q;
	logic [LVL_W-1:0]        level_q;
	logic [DUR_W-1:0]        amount_q;
	logic [TIME_BITS-1:0]    now_q;
	logic [DUR_W-1:0]        diff_q;

	logic [LVL_W-1:0]        fl_lvl_q;
	logic [DUR_W-1:0]        fl_t_q;
	logic                    fl_keep_q;

	logic [NUM_W-1:0]        div_num_q;
	logic [DEN_W-1:0]        div_den_q;
	logic [DEN_W-1:0]        div_rem_q;
	logic [CNT_W-1:0]        div_cnt_q;

	logic                    res_valid_q;
	logic [LVL_W-1:0]        out_level_q;
	logic                    fading_q;
	logic [PCT_W-1:0]        progress_q;
	logic [LVL_W-1:0]        target_q;

	// combinational helpers
	logic [TIME_BITS-1:0]    diff_w;
	logic [DUR_W-1:0]        diff16_w;
	logic                    diff_lt_iv;
	logic                    diff_ge_rem;
	logic [DUR_W:0]          slow_sum;
	logic [DUR_W-1:0]        slow_t;
	logic [LVL_W-1:0]        dist_start;
	logic [LVL_W-1:0]        dist_tick;
	logic                    up_w;
	logic [2*DUR_W-LVL_W-1:0] mag_prod;
	logic [NUM_W-1:0]        mag_num;
	logic [NUM_W-1:0]        frac_num;
	logic [NUM_W-1:0]        iv_num;
	logic [DEN_W:0]          div_shift;
	logic [DEN_W:0]          div_sub;
	logic                    div_ge;
	logic [QUO_W-1:0]        quo_w;
	logic [ACC_W:0]          acc_sum;
	logic [QUO_W-1:0]        up_sum;
	logic [PCT_PROD_W-1:0]   pct_prod;
	logic [PCT_PROD_W-PCT_SH-1:0] pct_raw;
	logic                    out_free;

	assign diff_w      = now_q - last_q;
	assign diff16_w    = DUR_W'(diff_w);
	assign diff_lt_iv  = CMP_W'(diff_w) < CMP_W'(step_iv_q);
	assign diff_ge_rem = CMP_W'(diff_w) >= CMP_W'(rem_q);

	assign slow_sum    = (DUR_W+1)'(rem_q) + (DUR_W+1)'(amount_q);
	assign slow_t      = slow_sum[DUR_W] ? {DUR_W{1'b1}} : slow_sum[DUR_W-1:0];

	assign dist_start  = (cur_q > fl_lvl_q) ? (cur_q - fl_lvl_q) : (fl_lvl_q - cur_q);
	assign up_w        = goal_q >= cur_q;
	assign dist_tick   = up_w ? (goal_q - cur_q) : (cur_q - goal_q);

	assign mag_prod    = (2*DUR_W-LVL_W)'(dist_tick) * (2*DUR_W-LVL_W)'(diff_q);
	assign mag_num     = (NUM_W'(mag_prod) << 1) + NUM_W'(rem_q);
	assign frac_num    = (NUM_W'(diff16_w) << FRAC_SH) + NUM_W'(rem_q);
	assign iv_num      = (NUM_W'(fl_t_q) << 1) + NUM_W'(dist_start);

	// one restoring step a cycle; the quotient shifts into the numerator register
	assign div_shift   = {div_rem_q, div_num_q[NUM_W-1]};
	assign div_sub     = div_shift - {1'b0, div_den_q};
	assign div_ge      = div_shift >= {1'b0, div_den_q};
	assign quo_w       = div_num_q[QUO_W-1:0];

	assign acc_sum     = (ACC_W+1)'(acc_q) + (ACC_W+1)'(quo_w);
	assign up_sum      = QUO_W'(cur_q) + quo_w;

	assign pct_prod    = PCT_PROD_W'(acc_q) * PCT_PROD_W'(PCT_SCALE)
		+ PCT_PROD_W'(FULL_Q16);
	assign pct_raw     = pct_prod[PCT_PROD_W-1:PCT_SH];

	assign out_free    = !res_valid_q || !result_stall;

	assign item_stall   = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = res_valid_q;
	assign out_level    = out_level_q;
	assign fading       = fading_q;
	assign progress     = progress_q;
	assign target_level = target_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dop_q       <= DOP_IV;
			enabled_q   <= 1'b1;
			min_iv_q    <= MIN_IV_RST;
			cur_q       <= '0;
			goal_q      <= '0;
			last_q      <= '0;
			step_iv_q   <= '0;
			rem_q       <= '0;
			acc_q       <= '0;
			func_q      <= FN_TICK;
			level_q     <= '0;
			amount_q    <= '0;
			now_q       <= '0;
			diff_q      <= '0;
			fl_lvl_q    <= '0;
			fl_t_q      <= '0;
			fl_keep_q   <= 1'b0;
			div_num_q   <= '0;
			div_den_q   <= '0;
			div_rem_q   <= '0;
			div_cnt_q   <= '0;
			res_valid_q <= 1'b0;
			out_level_q <= '0;
			fading_q    <= 1'b0;
			progress_q  <= '0;
			target_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_ENABLED:    enabled_q <= cfg_data[0];
					CFG_STEP_FLOOR: min_iv_q  <= cfg_data;
					default: ;
				endcase
			end

			if (res_valid_q && !result_stall && state_q != S_FIN)
				res_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						func_q   <= func_t'(func);
						level_q  <= level;
						amount_q <= amount;
						now_q    <= now_ms[TIME_BITS-1:0];
						state_q  <= S_DECODE;
					end
				end

				S_DECODE: begin
					if (enabled_q) begin
						unique case (func_q)
							FN_TICK: begin
								diff_q <= diff16_w;
								if (rem_q == '0 || diff_lt_iv) begin
									state_q <= S_FIN;
								end else if (diff_ge_rem) begin
									acc_q   <= FULL_Q16;
									rem_q   <= '0;
									cur_q   <= goal_q;
									state_q <= S_FIN;
								end else begin
									div_num_q <= frac_num;
									div_den_q <= DEN_W'({rem_q, 1'b0});
									div_rem_q <= '0;
									div_cnt_q <= CNT_W'(NUM_W);
									dop_q     <= DOP_FRAC;
									state_q   <= S_DIV;
								end
							end
							FN_START: begin
								fl_lvl_q  <= level_q;
								fl_t_q    <= amount_q;
								fl_keep_q <= 1'b0;
								state_q   <= S_START;
							end
							FN_SET: begin
								cur_q   <= level_q;
								state_q <= S_FIN;
							end
							FN_STOP: begin
								acc_q   <= FULL_Q16;
								rem_q   <= '0;
								state_q <= S_FIN;
							end
							FN_SLOWER: begin
								fl_lvl_q  <= goal_q;
								fl_t_q    <= slow_t;
								fl_keep_q <= 1'b1;
								state_q   <= S_START;
							end
							FN_FASTER: begin
								if (rem_q <= amount_q) begin
									rem_q   <= '0;
									cur_q   <= goal_q;
									state_q <= S_FIN;
								end else begin
									fl_lvl_q  <= goal_q;
									fl_t_q    <= rem_q - amount_q;
									fl_keep_q <= 1'b1;
									state_q   <= S_START;
								end
							end
							default: state_q <= S_FIN;
						endcase
					end else begin
						state_q <= S_FIN;
					end
				end

				S_START: begin
					if (!fl_keep_q)
						acc_q <= '0;
					if (fl_lvl_q == cur_q) begin
						rem_q   <= '0;
						state_q <= S_FIN;
					end else if (fl_t_q <= DUR_W'(min_iv_q)) begin
						rem_q   <= '0;
						cur_q   <= fl_lvl_q;
						state_q <= S_FIN;
					end else begin
						rem_q     <= fl_t_q;
						goal_q    <= fl_lvl_q;
						last_q    <= now_q;
						div_num_q <= iv_num;
						div_den_q <= DEN_W'({dist_start, 1'b0});
						div_rem_q <= '0;
						div_cnt_q <= CNT_W'(NUM_W);
						dop_q     <= DOP_IV;
						state_q   <= S_DIV;
					end
				end

				S_DIV: begin
					div_num_q <= {div_num_q[NUM_W-2:0], div_ge};
					div_rem_q <= div_ge ? div_sub[DEN_W-1:0] : div_shift[DEN_W-1:0];
					div_cnt_q <= div_cnt_q - CNT_W'(1);
					if (div_cnt_q == CNT_W'(1))
						state_q <= S_POST;
				end

				S_POST: begin
					unique case (dop_q)
						DOP_IV: begin
							if (quo_w < QUO_W'(min_iv_q))
								step_iv_q <= DUR_W'(min_iv_q);
							else
								step_iv_q <= quo_w[DUR_W-1:0];
							state_q <= S_FIN;
						end
						DOP_FRAC: begin
							if (acc_sum > (ACC_W+1)'(FULL_Q16))
								acc_q <= FULL_Q16;
							else
								acc_q <= acc_sum[ACC_W-1:0];
							// same divisor, now for the level step
							div_num_q <= mag_num;
							div_rem_q <= '0;
							div_cnt_q <= CNT_W'(NUM_W);
							dop_q     <= DOP_MAG;
							state_q   <= S_DIV;
						end
						DOP_MAG: begin
							if (up_w) begin
								if (up_sum > QUO_W'(LVL_MAX))
									cur_q <= LVL_MAX;
								else
									cur_q <= up_sum[LVL_W-1:0];
							end else begin
								if (quo_w > QUO_W'(cur_q))
									cur_q <= '0;
								else
									cur_q <= cur_q - quo_w[LVL_W-1:0];
							end
							rem_q   <= rem_q - diff_q;
							last_q  <= now_q;
							state_q <= S_FIN;
						end
						default: state_q <= S_FIN;
					endcase
				end

				S_FIN: begin
					// wait for the output register to free up
					if (out_free) begin
						res_valid_q <= 1'b1;
						out_level_q <= cur_q;
						fading_q    <= enabled_q && (rem_q != '0);
						progress_q  <= (pct_raw > (PCT_PROD_W-PCT_SH)'(PCT_MAX))
							? PCT_MAX : pct_raw[PCT_W-1:0];
						target_q    <= goal_q;
						state_q     <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: test/tb_pwm_led_fade_engine.sv
`default_nettype none

module tb_pwm_led_fade_engine;
	import plfe_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_WORDS = 590;

	typedef struct packed {
		logic [LVL_W-1:0] lvl;
		logic             fading;
		logic [PCT_W-1:0] pct;
		logic [LVL_W-1:0] tgt;
	} fade_out_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	logic [2:0]       func = '0;
	logic [LVL_W-1:0] level = '0;
	logic [15:0]      amount = '0;
	logic [31:0]      now_ms = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	logic [LVL_W-1:0] out_level;
	logic             fading;
	logic [PCT_W-1:0] progress;
	logic [LVL_W-1:0] target_level;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic             cfg_index = 1'b0;
	logic [7:0]       cfg_data = '0;

	pwm_led_fade_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.func(func),
		.level(level),
		.amount(amount),
		.now_ms(now_ms),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.out_level(out_level),
		.fading(fading),
		.progress(progress),
		.target_level(target_level),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// shadow copy of the fader
	logic                 sh_en = 1'b1;
	logic [7:0]           sh_min_iv = MIN_IV_RST;
	logic [LVL_W-1:0]     sh_level = '0;
	logic [LVL_W-1:0]     sh_goal = '0;
	logic [TIME_BITS-1:0] sh_stamp = '0;
	logic [15:0]          sh_interval = '0;
	logic [DUR_W-1:0]     sh_left = '0;
	logic [ACC_W-1:0]     sh_acc = '0;

	fade_out_t owed_outputs[$];

	int    n_bad = 0;
	int    n_sent = 0;
	int    cycles = 0;
	int    stall_left = 0;
	bit    gaps_on = 1'b0;
	bit    stall_on = 1'b0;
	logic [31:0] ms_clock = '0;

	function automatic void launch_fade(input logic [LVL_W-1:0] tgt, input logic [15:0] dur,
			input logic [31:0] stamp);
		logic [31:0] span;
		logic [31:0] iv;
		sh_left = '0;
		sh_acc = '0;
		if (tgt == sh_level)
			return;
		if (dur <= sh_min_iv) begin
			sh_level = tgt;
			return;
		end
		sh_left = dur;
		sh_goal = tgt;
		span = (sh_level > tgt) ? 32'(sh_level - tgt) : 32'(tgt - sh_level);
		iv = (2 * 32'(dur) + span) / (2 * span);
		if (iv < 32'(sh_min_iv))
			iv = 32'(sh_min_iv);
		sh_interval = iv[15:0];
		sh_stamp = stamp[TIME_BITS-1:0];
	endfunction

	function automatic void advance_fade(input logic [31:0] stamp);
		logic [TIME_BITS-1:0] d;
		logic [63:0] diff;
		logic [63:0] dur;
		logic [63:0] frac;
		logic [63:0] mag;
		logic [63:0] sum;
		logic [LVL_W-1:0] span;
		if (sh_left == 0)
			return;
		d = stamp[TIME_BITS-1:0] - sh_stamp;
		diff = 64'(d);
		if (diff < 64'(sh_interval))
			return;
		dur = 64'(sh_left);
		if (diff >= dur) begin
			sh_acc = FULL_Q16;
			sh_left = '0;
			sh_level = sh_goal;
			return;
		end
		frac = (diff * 131072 + dur) / (2 * dur);
		sum = 64'(sh_acc) + frac;
		sh_acc = (sum > 64'(FULL_Q16)) ? FULL_Q16 : sum[ACC_W-1:0];
		if (sh_goal >= sh_level) begin
			span = sh_goal - sh_level;
			mag = (64'(span) * diff * 2 + dur) / (2 * dur);
			sum = 64'(sh_level) + mag;
			sh_level = (sum > 64'(LVL_MAX)) ? LVL_MAX : sum[LVL_W-1:0];
		end else begin
			span = sh_level - sh_goal;
			mag = (64'(span) * diff * 2 + dur) / (2 * dur);
			sh_level = (mag > 64'(sh_level)) ? '0 : sh_level - mag[LVL_W-1:0];
		end
		sh_left = sh_left - diff[DUR_W-1:0];
		sh_stamp = stamp[TIME_BITS-1:0];
	endfunction

	// apply one word to the shadow fader and queue the output it must give
	function automatic void fader_apply(input logic [2:0] fn, input logic [LVL_W-1:0] lv,
			input logic [15:0] amt, input logic [31:0] stamp);
		fade_out_t o;
		logic [ACC_W-1:0] keep;
		logic [16:0] grown;
		logic [63:0] pct;
		if (sh_en) begin
			keep = sh_acc;
			case (fn)
				FN_TICK: advance_fade(stamp);
				FN_START: launch_fade(lv, amt, stamp);
				FN_SET: sh_level = lv;
				FN_STOP: begin
					sh_acc = FULL_Q16;
					sh_left = '0;
				end
				FN_SLOWER: begin
					grown = 17'(sh_left) + 17'(amt);
					if (grown > 17'd65535)
						grown = 17'd65535;
					launch_fade(sh_goal, grown[15:0], stamp);
					sh_acc = keep;
				end
				FN_FASTER: begin
					if (sh_left <= amt) begin
						sh_left = '0;
						sh_level = sh_goal;
					end else begin
						launch_fade(sh_goal, sh_left - amt, stamp);
					end
					sh_acc = keep;
				end
				default: ;
			endcase
		end
		pct = (64'(sh_acc) * PCT_SCALE + 65536) / 131072;
		if (pct > 64'(PCT_MAX))
			pct = 64'(PCT_MAX);
		o.lvl = sh_level;
		o.fading = sh_en && (sh_left != 0);
		o.pct = pct[PCT_W-1:0];
		o.tgt = sh_goal;
		owed_outputs.push_back(o);
	endfunction

	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic pick_stall();
		int r;
		if (!stall_on)
			return 1'b0;
		if (stall_left > 0) begin
			stall_left--;
			return 1'b1;
		end
		r = $urandom_range(0, 99);
		if (r < 60)
			return 1'b0;
		if (r < 93)
			stall_left = $urandom_range(0, 2);
		else
			stall_left = $urandom_range(8, 40);
		return 1'b1;
	endfunction

	// random bits above the time base, the live clock below it
	function automatic logic [31:0] stamp_now();
		logic [63:0] hi;
		hi = 64'($urandom) << TIME_BITS;
		return 32'(hi | (64'(ms_clock) & ((64'd1 << TIME_BITS) - 1)));
	endfunction

	task automatic send_word(input logic [2:0] fn, input logic [LVL_W-1:0] lv,
			input logic [15:0] amt, input logic [31:0] stamp);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		func <= fn;
		level <= lv;
		amount <= amt;
		now_ms <= stamp;
		do @(posedge clk); while (item_stall);
		fader_apply(fn, lv, amt, stamp);
		n_sent++;
	endtask

	task automatic drain_fader();
		item_valid <= 1'b0;
		while (owed_outputs.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// both registers in one burst, valid held high between the two words
	task automatic set_config(input logic en, input logic [7:0] miv);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_ENABLED;
		cfg_data <= {7'($urandom), en};
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_STEP_FLOOR;
		cfg_data <= miv;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sh_en = en;
		sh_min_iv = miv;
	endtask

	task automatic check_word();
		fade_out_t want;
		fade_out_t got;
		got = {out_level, fading, progress, target_level};
		if (owed_outputs.size() == 0) begin
			n_bad++;
			if (n_bad <= 10)
				$display("unexpected word: lvl=%0d fading=%0b pct=%0d tgt=%0d",
					got.lvl, got.fading, got.pct, got.tgt);
			return;
		end
		want = owed_outputs.pop_front();
		if (got.lvl !== want.lvl || got.fading !== want.fading || got.pct !== want.pct ||
				got.tgt !== want.tgt) begin
			n_bad++;
			if (n_bad <= 10)
				$display("mismatch: expected lvl=%0d fading=%0b pct=%0d tgt=%0d, got lvl=%0d fading=%0b pct=%0d tgt=%0d",
					want.lvl, want.fading, want.pct, want.tgt,
					got.lvl, got.fading, got.pct, got.tgt);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			check_word();
		result_stall <= pick_stall();
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic test_directed();
		gaps_on = 1'b0;
		stall_on = 1'b0;
		send_word(FN_SET, 8'd255, 16'd0, 32'd0);
		send_word(FN_SET, 8'd0, 16'hFFFF, 32'hFFFF_FFFF);
		send_word(FN_START, 8'd255, 16'd1000, 32'd100);
		send_word(FN_TICK, 8'd0, 16'd0, 32'd110);
		send_word(FN_TICK, 8'd0, 16'd0, 32'd150);
		send_word(FN_TICK, 8'd0, 16'd0, 32'd400);
		// level moved under a running fade
		send_word(FN_SET, 8'd100, 16'd0, 32'd500);
		send_word(FN_TICK, 8'd0, 16'd0, 32'd600);
		send_word(FN_SLOWER, 8'd0, 16'hFFFF, 32'd600);
		send_word(FN_TICK, 8'd0, 16'd0, 32'd700);
		send_word(FN_FASTER, 8'd0, 16'd100, 32'd710);
		send_word(FN_FASTER, 8'd0, 16'hFFFF, 32'd720);
		send_word(FN_START, 8'd255, 16'd5000, 32'd730);
		send_word(FN_START, 8'd0, 16'd20, 32'd740);
		// time base wraps between start and tick
		send_word(FN_START, 8'd200, 16'd21, 32'hFFFF_FFF0);
		send_word(FN_TICK, 8'd0, 16'd0, 32'h0000_0010);
		send_word(FN_START, 8'd0, 16'd3000, 32'h0001_FF00);
		send_word(FN_TICK, 8'd0, 16'd0, 32'h0002_0050);
		send_word(FN_STOP, 8'd0, 16'd0, 32'h0002_0060);
		send_word(FN_TICK, 8'd0, 16'd0, 32'h0002_9000);
		send_word(3'd6, 8'hAA, 16'h5555, 32'h5555_AAAA);
		send_word(3'd7, 8'h55, 16'hAAAA, 32'hAAAA_5555);
		send_word(FN_SLOWER, 8'd0, 16'd500, 32'h0002_9100);
		send_word(FN_TICK, 8'd0, 16'd0, 32'h0002_9200);
		send_word(FN_FASTER, 8'd0, 16'd0, 32'h0002_9300);
		drain_fader();
	endtask

	task automatic test_step_floor_extremes();
		set_config(1'b1, 8'd1);
		send_word(FN_SET, 8'd0, 16'd0, 32'd0);
		send_word(FN_START, 8'd255, 16'd2, 32'd1000);
		send_word(FN_TICK, 8'd0, 16'd0, 32'd1001);
		send_word(FN_START, 8'd10, 16'd1, 32'd1002);
		send_word(FN_START, 8'd0, 16'd3000, 32'd1003);
		send_word(FN_TICK, 8'd0, 16'd0, 32'd1004);
		drain_fader();
		set_config(1'b1, 8'd255);
		send_word(FN_START, 8'd200, 16'd255, 32'd2000);
		send_word(FN_START, 8'd0, 16'd256, 32'd2001);
		send_word(FN_TICK, 8'd0, 16'd0, 32'd2100);
		send_word(FN_TICK, 8'd0, 16'd0, 32'd2256);
		send_word(FN_TICK, 8'd0, 16'd0, 32'd2300);
		drain_fader();
		set_config(1'b1, MIN_IV_RST);
	endtask

	task automatic test_disabled();
		send_word(FN_SET, 8'd50, 16'd0, 32'd3000);
		send_word(FN_START, 8'd200, 16'd5000, 32'd3000);
		drain_fader();
		set_config(1'b0, MIN_IV_RST);
		for (int f = 0; f < 8; f++)
			send_word(3'(f), 8'($urandom), 16'($urandom), $urandom);
		drain_fader();
		set_config(1'b1, MIN_IV_RST);
		// fade picks up where it stood
		send_word(FN_TICK, 8'd0, 16'd0, 32'd3400);
		drain_fader();
	endtask

	function automatic logic [15:0] pick_duration();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 16'($urandom_range(0, sh_min_iv));
		if (r < 65)
			return 16'($urandom_range(21, 2000));
		if (r < 90)
			return 16'($urandom_range(2000, 20000));
		return 16'($urandom_range(20000, 65535));
	endfunction

	task automatic run_fade_sequence();
		int r;
		if ($urandom_range(0, 1))
			send_word(FN_SET, 8'($urandom), 16'($urandom), stamp_now());
		send_word(FN_START, 8'($urandom), pick_duration(), stamp_now());
		for (int k = 0; k < 25 && sh_left != 0; k++) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				send_word(3'($urandom), 8'($urandom), 16'($urandom), $urandom);
			else if (r < 14)
				send_word(FN_SLOWER, 8'($urandom),
					($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 500)),
					stamp_now());
			else if (r < 20)
				send_word(FN_FASTER, 8'($urandom),
					($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 500)),
					stamp_now());
			else if (r < 23)
				send_word(FN_SET, 8'($urandom), 16'($urandom), stamp_now());
			else if (r < 25)
				send_word(FN_STOP, 8'($urandom), 16'($urandom), stamp_now());
			else begin
				if ($urandom_range(0, 9) == 0)
					ms_clock += $urandom_range(0, 70000);
				else
					ms_clock += $urandom_range(0, 2 * sh_interval + 2);
				send_word(FN_TICK, 8'($urandom), 16'($urandom), stamp_now());
			end
		end
	endtask

	task automatic test_random_fades(input int quota);
		int base;
		int chunk;
		int chunk_start;
		base = n_sent;
		chunk = 0;
		ms_clock = 32'h0003_0000;
		while (n_sent - base < quota) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			stall_on = ($urandom_range(0, 3) != 0);
			case (chunk % 5)
				0: set_config(1'b1, MIN_IV_RST);
				1: set_config(1'b1, 8'd1);
				2: set_config(1'b1, 8'd255);
				3: set_config(1'b1, 8'($urandom_range(1, 255)));
				default: set_config(1'b0, 8'($urandom_range(1, 255)));
			endcase
			if (!sh_en) begin
				// words that the block ignores while off do not count
				repeat (12)
					send_word(3'($urandom), 8'($urandom), 16'($urandom), $urandom);
				base += 12;
			end else begin
				chunk_start = n_sent;
				while (n_sent - chunk_start < 120 && n_sent - base < quota)
					run_fade_sequence();
			end
			drain_fader();
			chunk++;
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_step_floor_extremes();
		test_disabled();
		test_random_fades(RANDOM_WORDS);
		drain_fader();
		repeat (200) @(posedge clk);
		if (n_bad == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
rtl/core/plfe_pkg.sv
rtl/core/pwm_led_fade_engine.sv
test/tb_pwm_led_fade_engine.sv
